[rtl/core/ibpp_pkg.sv]
package ibpp_pkg;

  localparam int DEF_PACKETS = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int PKT_LEN     = 11;
  localparam int SUM_POS     = 10;
  localparam int DATA_BYTES  = 8;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_IDLE  = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_QUAT  = 8'h59;

  localparam logic [1:0] GRP_ACCEL = 2'd0;
  localparam logic [1:0] GRP_GYRO  = 2'd1;
  localparam logic [1:0] GRP_ANGLE = 2'd2;
  localparam logic [1:0] GRP_QUAT  = 2'd3;

  typedef enum logic {
    ST_COLLECT,
    ST_WALK
  } front_state_t;

  typedef struct packed {
    logic       known;
    logic [1:0] group;
  } type_info_t;

  typedef struct packed {
    logic [1:0]              group;
    logic [8*DATA_BYTES-1:0] data;
    logic                    last;
  } pkt_rec_t;

  function automatic type_info_t decode_type(input logic [7:0] t);
    type_info_t info;
    info.known = 1'b1;
    info.group = GRP_ACCEL;
    case (t)
      TYPE_ACCEL: info.group = GRP_ACCEL;
      TYPE_GYRO:  info.group = GRP_GYRO;
      TYPE_ANGLE: info.group = GRP_ANGLE;
      TYPE_QUAT:  info.group = GRP_QUAT;
      default:    info.known = 1'b0;
    endcase
    return info;
  endfunction

endpackage

[rtl/core/imu_burst_packet_parser.sv]
// Channel  Ports                                         Direction
// input    in_valid, in_ready, in_op, in_rx_byte         into the block
// result   out_valid, out_ready, out_group, out_word0-3,
//          out_valid_words, out_last                     out of the block
//
// A byte or error word is taken without delay, and so is an idle word that yields nothing.
// An idle word that yields results starts a walk over the packet slots, during
// which no input word is taken; the walk stalls while the two-entry queue is full.
// Results leave through a registered output stage one per cycle when out_ready is high.
// Reset is synchronous and active low; slot contents are not cleared by it.
module imu_burst_packet_parser
  import ibpp_pkg::*;
#(
  parameter int PACKETS_PER_BURST = DEF_PACKETS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_group,
  output logic [15:0] out_word0,
  output logic [15:0] out_word1,
  output logic [15:0] out_word2,
  output logic [15:0] out_word3,
  output logic [2:0]  out_valid_words,
  output logic        out_last
);

  logic     push_valid, push_ready;
  pkt_rec_t push_rec;
  logic     pop_valid, pop_ready;
  pkt_rec_t pop_rec;

  ibpp_front #(
    .PACKETS(PACKETS_PER_BURST)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  ibpp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_rec   (push_rec),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_rec   (pop_rec)
  );

  ibpp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_valid       (pop_valid),
    .rec_ready       (pop_ready),
    .rec             (pop_rec),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_group       (out_group),
    .out_word0       (out_word0),
    .out_word1       (out_word1),
    .out_word2       (out_word2),
    .out_word3       (out_word3),
    .out_valid_words (out_valid_words),
    .out_last        (out_last)
  );

endmodule

[rtl/core/ibpp_front.sv]
module ibpp_front
  import ibpp_pkg::*;
#(
  parameter int PACKETS = DEF_PACKETS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_rx_byte,
  output logic       push_valid,
  input  logic       push_ready,
  output pkt_rec_t   push_rec
);

  localparam int BURST_LEN = PKT_LEN * PACKETS;
  localparam int CW        = $clog2(BURST_LEN + 2);
  localparam int PW        = (PACKETS > 1) ? $clog2(PACKETS) : 1;

  front_state_t state_r, state_nxt;

  logic [CW-1:0]               byte_count_r;
  logic [3:0]                  off_r;
  logic [PW-1:0]               pkt_r;
  logic [7:0]                  running_sum_r;
  logic                        header_good_r;
  logic [PACKETS-1:0]          sum_ok_r;
  logic [PACKETS-1:0]          keep_r;
  logic [PW-1:0]               walk_idx_r;
  logic [7:0]                  slot_type_r [PACKETS];
  logic [8*DATA_BYTES-1:0]     slot_data_r [PACKETS];

  logic               in_fire, byte_fire, idle_fire, err_fire, take;
  logic               advance, walk_done;
  logic [PACKETS-1:0] keep_mask;
  logic [PACKETS-1:0] rest;
  logic [2:0]         data_lane;
  type_info_t         walk_info;

  assign in_fire   = in_valid && in_ready;
  assign byte_fire = in_fire && (in_op == OP_BYTE);
  assign idle_fire = in_fire && (in_op == OP_IDLE);
  assign err_fire  = in_fire && (in_op == OP_ERROR);
  assign take      = byte_fire && (byte_count_r < CW'(BURST_LEN));
  assign data_lane = 3'(off_r - 4'd2);

  always_comb begin
    type_info_t slot_info;
    slot_info = '0;
    for (int p = 0; p < PACKETS; p++) begin
      slot_info    = decode_type(slot_type_r[p]);
      keep_mask[p] = sum_ok_r[p] && slot_info.known;
    end
    if (!(header_good_r && (byte_count_r == CW'(BURST_LEN)))) begin
      keep_mask = '0;
    end
  end

  assign walk_info = decode_type(slot_type_r[walk_idx_r]);
  assign rest      = keep_r >> walk_idx_r;
  assign walk_done = (walk_idx_r == PW'(PACKETS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: begin
        if (idle_fire && (keep_mask != '0)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance && walk_done) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    advance    = 1'b0;
    case (state_r)
      ST_COLLECT: in_ready = 1'b1;
      ST_WALK: begin
        push_valid = keep_r[walk_idx_r];
        advance    = !keep_r[walk_idx_r] || push_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign push_rec.group = walk_info.group;
  assign push_rec.data  = slot_data_r[walk_idx_r];
  assign push_rec.last  = ((rest >> 1) == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_COLLECT;
      byte_count_r  <= '0;
      off_r         <= '0;
      pkt_r         <= '0;
      running_sum_r <= '0;
      header_good_r <= 1'b0;
      sum_ok_r      <= '0;
      keep_r        <= '0;
      walk_idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (idle_fire || err_fire) begin
        byte_count_r  <= '0;
        off_r         <= '0;
        pkt_r         <= '0;
        running_sum_r <= '0;
        header_good_r <= 1'b0;
        sum_ok_r      <= '0;
      end else if (byte_fire && !take) begin
        byte_count_r <= CW'(BURST_LEN + 1);
      end else if (take) begin
        byte_count_r <= byte_count_r + 1'b1;
        if (byte_count_r == '0) begin
          header_good_r <= (in_rx_byte == HDR_BYTE);
        end else if (byte_count_r == CW'(1)) begin
          header_good_r <= header_good_r && (in_rx_byte == TYPE_ACCEL);
        end
        if (off_r == 4'd0) begin
          running_sum_r <= in_rx_byte;
        end else if (off_r < 4'(SUM_POS)) begin
          running_sum_r <= running_sum_r + in_rx_byte;
        end else begin
          sum_ok_r[pkt_r] <= (running_sum_r == in_rx_byte);
        end
        if (off_r == 4'(SUM_POS)) begin
          off_r <= '0;
          pkt_r <= pkt_r + 1'b1;
        end else begin
          off_r <= off_r + 1'b1;
        end
      end
      if (idle_fire) begin
        keep_r     <= keep_mask;
        walk_idx_r <= '0;
      end else if (advance) begin
        walk_idx_r <= walk_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (off_r == 4'd1) begin
        slot_type_r[pkt_r] <= in_rx_byte;
      end else if ((off_r >= 4'd2) && (off_r < 4'(SUM_POS))) begin
        slot_data_r[pkt_r][{data_lane, 3'b000} +: 8] <= in_rx_byte;
      end
    end
  end

endmodule

[rtl/core/ibpp_queue.sv]
module ibpp_queue
  import ibpp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  pkt_rec_t wr_rec,
  output logic     rd_valid,
  input  logic     rd_ready,
  output pkt_rec_t rd_rec
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  pkt_rec_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          wr_fire, rd_fire;

  assign wr_ready = (count_r != NW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count_r <= count_r + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

[rtl/core/ibpp_back.sv]
module ibpp_back
  import ibpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rec_valid,
  output logic        rec_ready,
  input  pkt_rec_t    rec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_group,
  output logic [15:0] out_word0,
  output logic [15:0] out_word1,
  output logic [15:0] out_word2,
  output logic [15:0] out_word3,
  output logic [2:0]  out_valid_words,
  output logic        out_last
);

  logic        out_valid_r;
  logic [1:0]  group_r;
  logic [15:0] word0_r, word1_r, word2_r, word3_r;
  logic [2:0]  valid_words_r;
  logic        last_r;
  logic        three_words;

  assign rec_ready   = !out_valid_r || out_ready;
  assign three_words = (rec.group == GRP_ACCEL) || (rec.group == GRP_ANGLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_ready) begin
      out_valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      group_r       <= rec.group;
      word0_r       <= rec.data[15:0];
      word1_r       <= rec.data[31:16];
      word2_r       <= rec.data[47:32];
      word3_r       <= three_words ? 16'd0 : rec.data[63:48];
      valid_words_r <= three_words ? 3'd3 : 3'd4;
      last_r        <= rec.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_group       = group_r;
  assign out_word0       = word0_r;
  assign out_word1       = word1_r;
  assign out_word2       = word2_r;
  assign out_word3       = word3_r;
  assign out_valid_words = valid_words_r;
  assign out_last        = last_r;

endmodule
